[rtl/mqsb_pkg.sv]
// Shared types, constants and helpers for the multi-queue shared buffer.
// Used by mqsb_link_ram, mqsb_data_ram and multi_queue_shared_buffer.
package mqsb_pkg;

  localparam int SLOTS   = 16;
  localparam int QUEUES  = 4;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LINK_W  = $clog2(SLOTS + 1);
  localparam int DATA_W  = 32;
  localparam int QID_W   = 2;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [LINK_W-1:0] link_t;

  localparam link_t LINK_NIL = link_t'(SLOTS);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;

  typedef struct packed {
    logic                     op;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] push_data;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_data;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic      wr_en;
    slot_idx_t wr_addr;
    link_t     wr_data;
    slot_idx_t rd_addr;
  } link_req_t;

  typedef struct packed {
    logic              wr_en;
    slot_idx_t         wr_addr;
    logic [DATA_W-1:0] wr_data;
    slot_idx_t         rd_addr;
  } data_req_t;

  function automatic logic is_slot(link_t x);
    return x < link_t'(SLOTS);
  endfunction

  // Reset chain: every slot points at the next, the last one at null.
  function automatic link_t link_init(slot_idx_t i);
    return link_t'(i) + link_t'(1);
  endfunction

endpackage

[rtl/multi_queue_shared_buffer.sv]
// Top level: several FIFO queues threaded through one shared slot store.
// Depends on mqsb_pkg, mqsb_link_ram and mqsb_data_ram.
//
//   channel   handshake             payload
//   input     start, busy           in_item  (op, queue_id, push_data)
//   result    out_valid (strobe)    out_item (pop_data, status)
//
// Each item passes IDLE then EXEC: the accept cycle reads the link and
// data stores, the EXEC cycle uses the link read back and writes the freed
// or new link. One result per item, strobed the cycle after that; busy is
// high in EXEC, so a new item is only taken once the last one leaves it.
// Synchronous active-low reset empties every queue and threads all slots
// into the free list; no clearing pass is needed. Results cannot be stalled.
module multi_queue_shared_buffer
  import mqsb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic              op_r;
  logic [QID_W-1:0]  q_r;
  logic              ok_r;
  link_t             slot_r;
  link_t             free_head_r;
  link_t             head_r [QUEUES];
  link_t             tail_r [QUEUES];
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              accept;
  logic              q_in_range;
  logic              push_ok;
  logic              pop_ok;
  logic              item_ok;
  link_t             sel_slot;
  link_t             cur_head;
  link_t             cur_tail;
  link_req_t         link_req;
  data_req_t         data_req;
  link_t             link_rd;
  logic [DATA_W-1:0] data_rd;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r == ST_EXEC);
  assign q_in_range = int'(in_item.queue_id) < QUEUES;
  assign cur_head   = head_r[in_item.queue_id];
  assign cur_tail   = tail_r[in_item.queue_id];
  assign push_ok    = q_in_range && is_slot(free_head_r);
  assign pop_ok     = q_in_range && is_slot(cur_head);
  assign item_ok    = (in_item.op == OP_POP) ? pop_ok : push_ok;
  assign sel_slot   = (in_item.op == OP_POP) ? cur_head : free_head_r;

  always_comb begin
    link_req         = '0;
    link_req.rd_addr = sel_slot[SLOT_W-1:0];
    if (state_r == ST_EXEC) begin
      // close the item's own slot: null for a push, free-list head for a pop
      link_req.wr_en   = ok_r;
      link_req.wr_addr = slot_r[SLOT_W-1:0];
      link_req.wr_data = (op_r == OP_POP) ? free_head_r : LINK_NIL;
    end else begin
      // append the new slot behind a live tail
      link_req.wr_en   = accept && (in_item.op == OP_PUSH) && push_ok &&
                         is_slot(cur_head) && is_slot(cur_tail);
      link_req.wr_addr = cur_tail[SLOT_W-1:0];
      link_req.wr_data = free_head_r;
    end
  end

  always_comb begin
    data_req         = '0;
    data_req.rd_addr = sel_slot[SLOT_W-1:0];
    data_req.wr_en   = accept && (in_item.op == OP_PUSH) && push_ok;
    data_req.wr_addr = free_head_r[SLOT_W-1:0];
    data_req.wr_data = in_item.push_data;
  end

  mqsb_link_ram u_link_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (link_req),
    .rd_data (link_rd)
  );

  mqsb_data_ram u_data_ram (
    .clk     (clk),
    .req     (data_req),
    .rd_data (data_rd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < QUEUES; i++) begin
        head_r[i] <= LINK_NIL;
        tail_r[i] <= LINK_NIL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
      if (accept && (in_item.op == OP_PUSH) && push_ok) begin
        if (!is_slot(cur_head)) begin
          head_r[in_item.queue_id] <= free_head_r;
        end
        tail_r[in_item.queue_id] <= free_head_r;
      end
      if ((state_r == ST_EXEC) && ok_r) begin
        if (op_r == OP_POP) begin
          head_r[q_r] <= link_rd;
          free_head_r <= slot_r;
        end else begin
          free_head_r <= link_rd;
        end
      end
    end
  end

  // item context and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_item.op;
      q_r    <= in_item.queue_id;
      ok_r   <= item_ok;
      slot_r <= sel_slot;
    end
    if (state_r == ST_EXEC) begin
      if (op_r == OP_POP) begin
        out_item_r.pop_data <= ok_r ? data_rd : '1;
        out_item_r.status   <= ok_r ? STATUS_OK : STATUS_EMPTY;
      end else begin
        out_item_r.pop_data <= '0;
        out_item_r.status   <= ok_r ? STATUS_OK : STATUS_OVERFLOW;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/mqsb_link_ram.sv]
// Next-link store: one write and one registered read per cycle.
// Entries not yet written read as the reset chain. Depends on mqsb_pkg.
module mqsb_link_ram
  import mqsb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  link_req_t req,
  output link_t     rd_data
);

  link_t            mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  link_t            rd_q_r;
  logic             rd_valid_r;
  slot_idx_t        rd_addr_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_q_r    <= mem[req.rd_addr];
    rd_addr_r <= req.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[req.rd_addr];
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : link_init(rd_addr_r);

endmodule

[rtl/mqsb_data_ram.sv]
// Slot data store: one write and one registered read per cycle.
// Contents undefined until written. Depends on mqsb_pkg.
module mqsb_data_ram
  import mqsb_pkg::*;
(
  input  logic              clk,
  input  data_req_t         req,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [SLOTS];
  logic [DATA_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_q_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_q_r;

endmodule

[tb/mqsb_checker.sv]
`timescale 1ns / 100ps
// Result checker for multi_queue_shared_buffer: tracks the queues and free list itself,
// predicts each result and compares it with what the block returns. Depends on mqsb_pkg.
module mqsb_checker
  import mqsb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        outstanding
);

  logic [DATA_W-1:0] slot_val [SLOTS];
  link_t             next_slot [SLOTS];
  link_t             head_of [QUEUES];
  link_t             tail_of [QUEUES];
  link_t             free_top;
  out_item_t         due_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic clear_queues();
    for (int i = 0; i < SLOTS; i++) begin
      slot_val[i]  = '0;
      next_slot[i] = (i + 1 < SLOTS) ? link_t'(i + 1) : LINK_NIL;
    end
    for (int i = 0; i < QUEUES; i++) begin
      head_of[i] = LINK_NIL;
      tail_of[i] = LINK_NIL;
    end
    free_top = '0;
  endtask

  // Apply one push or pop to the local copy and return the answer it earns.
  task automatic predict_queue_op(input in_item_t it, output out_item_t res);
    slot_idx_t        s;
    logic [QID_W-1:0] q;
    q = it.queue_id;
    if (it.op == OP_PUSH) begin
      res.pop_data = '0;
      if (int'(q) >= QUEUES || free_top >= LINK_NIL) begin
        res.status = STATUS_OVERFLOW;
      end else begin
        s        = free_top[SLOT_W-1:0];
        free_top = next_slot[s];
        if (head_of[q] >= LINK_NIL) begin
          head_of[q] = link_t'(s);
        end else if (tail_of[q] < LINK_NIL) begin
          next_slot[tail_of[q][SLOT_W-1:0]] = link_t'(s);
        end
        next_slot[s] = LINK_NIL;
        tail_of[q]   = link_t'(s);
        slot_val[s]  = it.push_data;
        res.status   = STATUS_OK;
      end
    end else begin
      if (int'(q) >= QUEUES || head_of[q] >= LINK_NIL) begin
        res.pop_data = '1;
        res.status   = STATUS_EMPTY;
      end else begin
        s            = head_of[q][SLOT_W-1:0];
        head_of[q]   = next_slot[s];
        next_slot[s] = free_top;
        free_top     = link_t'(s);
        res.pop_data = slot_val[s];
        res.status   = STATUS_OK;
      end
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t mqsb_checker: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      clear_queues();
      due_results.delete();
    end else begin
      // Compare before predicting: a result always belongs to an older item.
      if (out_valid) begin
        got = out_item;
        if (due_results.size() == 0) begin
          note_failure($sformatf("result with nothing due: pop_data %h status %0d",
                                 got.pop_data, got.status));
        end else begin
          want = due_results.pop_front();
          if (got.pop_data !== want.pop_data || got.status !== want.status) begin
            note_failure($sformatf("pop_data exp %h got %h, status exp %0d got %0d",
                                   want.pop_data, got.pop_data, want.status, got.status));
          end
        end
      end
      if (start && !busy) begin
        predict_queue_op(in_item, want);
        due_results.push_back(want);
      end
    end
    outstanding <= due_results.size();
  end

endmodule

[tb/multi_queue_shared_buffer_tb.sv]
`timescale 1ns / 100ps
// Testbench top for multi_queue_shared_buffer: drives pushes and pops and gives the verdict.
// Depends on mqsb_pkg, the block itself and mqsb_checker.
module multi_queue_shared_buffer_tb;
  import mqsb_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        outstanding;
  int        quiet_cycles;

  multi_queue_shared_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  mqsb_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold start until the item is taken, then idle the sender now and again.
  task automatic send_item(input in_item_t it, input int idle_pct);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic push_to(input int q, input logic [DATA_W-1:0] d);
    in_item_t it;
    it.op        = OP_PUSH;
    it.queue_id  = QID_W'(q);
    it.push_data = d;
    send_item(it, 19);
  endtask

  task automatic pop_from(input int q);
    in_item_t it;
    it.op        = OP_POP;
    it.queue_id  = QID_W'(q);
    it.push_data = $urandom;
    send_item(it, 19);
  endtask

  function automatic logic [DATA_W-1:0] pick_data();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '1;
      default: return '0;
    endcase
  endfunction

  // Alternate filling and draining stretches so the store swings between
  // overflow and empty queues.
  task automatic run_phase(input int n_items, input int idle_pct);
    in_item_t it;
    int       left_in_mode;
    bit       draining;
    left_in_mode = 0;
    draining     = 1'b0;
    for (int n = 0; n < n_items; n++) begin
      if (left_in_mode == 0) begin
        draining     = 1'($urandom_range(0, 1));
        left_in_mode = $urandom_range(8, 40);
      end
      left_in_mode--;
      it.op        = ($urandom_range(0, 99) < (draining ? 75 : 25)) ? OP_POP : OP_PUSH;
      it.queue_id  = QID_W'($urandom_range(0, QUEUES - 1));
      it.push_data = pick_data();
      send_item(it, idle_pct);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("multi_queue_shared_buffer_tb: errors");
      $finish;
    end
  end

  initial begin
    quiet_cycles = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pop before anything is stored, then data extremes on queues 0 to 2, a pattern on queue 3.
    pop_from(0);
    push_to(0, 32'h7FFF_FFFF);
    push_to(0, 32'h8000_0000);
    push_to(1, '1);
    push_to(2, '0);
    push_to(3, 32'hA5A5_A5A5);
    pop_from(0);
    pop_from(0);
    pop_from(0);
    // Queue 0 now keeps a stale tail; the next push must restart it.
    push_to(0, 32'h5A5A_5A5A);
    pop_from(0);
    // Use up every slot, then push once more to overflow.
    for (int i = 0; i < SLOTS - 3; i++) push_to(i % QUEUES, $urandom);
    push_to(1, $urandom);

    run_phase(510, 19);
    run_phase(510, 80);
    run_phase(510, 0);
    start <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("multi_queue_shared_buffer_tb: clean");
    end else begin
      $display("multi_queue_shared_buffer_tb: errors");
    end
    $finish;
  end

endmodule
